[rtl/grcf_pkg.sv]
// shared constants, types and helpers for the rainbow gradient chase frame block
`timescale 1ns / 1ps

package grcf_pkg;

  localparam int NUM_PIXELS = 64;
  localparam int PIX_W      = $clog2(NUM_PIXELS);
  localparam int MAX_STOPS  = 8;
  localparam int STOP_W     = 3;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int DVD_W      = 2 * CH_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [3:0] STOPS_MIN = 4'd2;
  localparam logic [3:0] STOPS_MAX = 4'(MAX_STOPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_STOPS     = 3'd0,
    REG_NUM_STEPS     = 3'd1,
    REG_LIT_RUN       = 3'd2,
    REG_DARK_RUN      = 3'd3,
    REG_CHASE_REVERSE = 3'd4
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } item_kind_t;

  // a small value modulo a stop count of 2..8, by repeated subtraction
  function automatic logic [3:0] mod_stops(input logic [3:0] a, input logic [3:0] m);
    logic [3:0] r;
    r = a;
    for (int k = 0; k < 4; k++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

[rtl/grcf_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module grcf_div
  import grcf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [CH_W-1:0]  divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [CH_W-1:0]  rem;
  logic [DVD_W-1:0] quo;
  logic [CH_W-1:0]  dsr;
  logic [CH_W:0]    trial;

  assign trial    = {rem, quo[DVD_W-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
        rem   <= '0;
        quo   <= dividend;
        dsr   <= divisor;
      end else if (busy) begin
        // remainder stays below the divisor, so it fits the channel width
        if (trial >= {1'b0, dsr}) begin
          rem <= CH_W'(trial - {1'b0, dsr});
          quo <= {quo[DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[CH_W-1:0];
          quo <= {quo[DVD_W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/rainbow_gradient_chase_frame.sv]
// top level: palette, chase mask and per-pixel gradient walk under one sequencer
`timescale 1ns / 1ps

// Each frame tick produces 64 pixel transfers in index order; palette write items
// produce none and are taken while idle. A tick first builds the chase mask, one
// pixel a cycle, then renders the colours. Every division (the ramp of pixel 0 and
// the per-channel step size) runs through one shared divider, so pixel 0 needs six
// divisions and a pixel where the local goal moves to the next stop needs three. The
// block accepts no item until the last pixel of the frame has been taken.
// Configuration is taken at any time through cfg_we/cfg_index/cfg_data and is meant to
// change only while idle.
module rainbow_gradient_chase_frame
  import grcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 kind,
  input  logic [STOP_W-1:0]    stop_index,
  input  logic [COLOR_W-1:0]   stop_color,
  // result items
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [PIX_W-1:0]     pixel_index,
  output logic [CH_W-1:0]      red,
  output logic [CH_W-1:0]      green,
  output logic [CH_W-1:0]      blue,
  output logic                 last,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CH_W-1:0]      cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MASK  = 11'b00000000010,
    S_FETCH = 11'b00000000100,
    S_RMUL  = 11'b00000001000,
    S_RDIV  = 11'b00000010000,
    S_SDIV  = 11'b00000100000,
    S_ADV   = 11'b00001000000,
    S_WSET  = 11'b00010000000,
    S_WDIV  = 11'b00100000000,
    S_WALK  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [3:0]      num_stops;
  logic [CH_W-1:0] num_steps;
  logic [CH_W-1:0] lit_run;
  logic [CH_W-1:0] dark_run;
  logic            chase_reverse;

  // frame-to-frame state
  logic [COLOR_W-1:0] palette [MAX_STOPS];
  logic [STOP_W-1:0]  goal_stop;
  logic [CH_W-1:0]    ramp_step;
  logic               first_lit;
  logic [CH_W-1:0]    first_run_count;

  // per-frame working registers
  logic [NUM_PIXELS-1:0] blank;
  logic [PIX_W-1:0]      pix;
  logic                  run_on;
  logic [CH_W-1:0]       run_left;
  logic [STOP_W-1:0]     local_stop;
  logic [1:0]            ch;
  logic [CH_W-1:0]       v [3];
  logic [CH_W-1:0]       g [3];
  logic [CH_W-1:0]       s [3];
  logic [CH_W-1:0]       d [3];

  // shared divider
  logic             div_go;
  logic [DVD_W-1:0] dvd;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  // effective settings: stop count clamped, zero divisor and runs act as one
  logic [3:0]      stops;
  logic [CH_W-1:0] steps;
  logic [CH_W-1:0] on_len;
  logic [CH_W-1:0] off_len;

  assign stops   = (num_stops < STOPS_MIN) ? STOPS_MIN :
                   (num_stops > STOPS_MAX) ? STOPS_MAX : num_stops;
  assign steps   = (num_steps == '0) ? CH_W'(1) : num_steps;
  assign on_len  = (lit_run   == '0) ? CH_W'(1) : lit_run;
  assign off_len = (dark_run  == '0) ? CH_W'(1) : dark_run;

  grcf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (dvd),
    .divisor  (steps),
    .done     (div_done),
    .quotient (div_q)
  );

  // handshake and payload
  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_OUT);
  assign pixel_index  = pix;
  assign last         = (pix == PIX_W'(NUM_PIXELS - 1));
  assign red          = blank[pix] ? '0 : v[0];
  assign green        = blank[pix] ? '0 : v[1];
  assign blue         = blank[pix] ? '0 : v[2];

  // combinational helpers for the sequencer
  logic [STOP_W-1:0] start_idx;
  logic [CH_W-1:0]   cur_diff;
  logic [CH_W-1:0]   walk_diff;
  logic [CH_W-1:0]   step_q;
  logic              at_goal;
  logic [3:0]        next_local;
  logic [3:0]        next_goal;
  logic [CH_W:0]     run_next;
  logic [CH_W-1:0]   left_dec;
  logic [PIX_W-1:0]  mask_pos;

  assign start_idx  = (goal_stop != '0) ? goal_stop - 1'b1 : STOP_W'(stops - 1'b1);
  assign cur_diff   = abs_diff(g[ch], s[ch]);
  assign walk_diff  = abs_diff(g[ch], v[ch]);
  assign step_q     = (div_q[DVD_W-1:CH_W] == '0 && div_q[CH_W-1:0] == '0) ?
                      CH_W'(1) : div_q[CH_W-1:0];
  assign at_goal    = (v[0] == g[0]) && (v[1] == g[1]) && (v[2] == g[2]);
  assign next_local = mod_stops({1'b0, local_stop} + 4'd1, stops);
  assign next_goal  = mod_stops({1'b0, goal_stop} + 4'd1, stops);
  assign run_next   = {1'b0, first_run_count} + 1'b1;
  assign left_dec   = run_left - 1'b1;
  assign mask_pos   = chase_reverse ? PIX_W'(NUM_PIXELS - 1) - pix : pix;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      num_stops     <= 4'd7;
      num_steps     <= 8'd16;
      lit_run       <= 8'd3;
      dark_run      <= 8'd3;
      chase_reverse <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_STOPS:     num_stops     <= cfg_data[3:0];
        REG_NUM_STEPS:     num_steps     <= cfg_data;
        REG_LIT_RUN:       lit_run       <= cfg_data;
        REG_DARK_RUN:      dark_run      <= cfg_data;
        REG_CHASE_REVERSE: chase_reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // palette writes, accepted only while idle
  always_ff @(posedge clk) begin
    if (item_valid && item_ready && kind == KIND_WRITE) begin
      palette[stop_index] <= stop_color;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      goal_stop       <= STOP_W'(1);
      ramp_step       <= '0;
      first_lit       <= 1'b1;
      first_run_count <= CH_W'(1);
      div_go          <= 1'b0;
      pix             <= '0;
      ch              <= '0;
    end else begin
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid && kind == KIND_TICK) begin
            // chase phase carried over from the previous frame
            run_on   <= first_lit;
            run_left <= (first_run_count == '0) ? (first_lit ? on_len : off_len)
                                                : first_run_count;
            pix      <= '0;
            state    <= S_MASK;
          end
        end
        S_MASK: begin
          // one mask bit per cycle, mirrored when chase_reverse is set
          blank[mask_pos] <= !run_on;
          if (left_dec == '0) begin
            run_on   <= !run_on;
            run_left <= run_on ? off_len : on_len;
          end else begin
            run_left <= left_dec;
          end
          pix <= pix + 1'b1;
          if (pix == PIX_W'(NUM_PIXELS - 1)) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // previous stop and goal stop for pixel 0
          for (int c = 0; c < 3; c++) begin
            s[c] <= palette[start_idx][(2 - c) * CH_W +: CH_W];
            g[c] <= palette[goal_stop][(2 - c) * CH_W +: CH_W];
          end
          local_stop <= goal_stop;
          ch         <= '0;
          state      <= S_RMUL;
        end
        S_RMUL: begin
          // ramp * diff, registered before the divider
          dvd    <= ramp_step * cur_diff;
          div_go <= 1'b1;
          state  <= S_RDIV;
        end
        S_RDIV: begin
          if (div_done) begin
            // saturate at the goal colour
            if (div_q >= DVD_W'(cur_diff)) begin
              v[ch] <= g[ch];
            end else if (g[ch] > s[ch]) begin
              v[ch] <= s[ch] + div_q[CH_W-1:0];
            end else begin
              v[ch] <= s[ch] - div_q[CH_W-1:0];
            end
            dvd    <= DVD_W'(cur_diff);
            div_go <= 1'b1;
            state  <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            d[ch] <= step_q;
            if (ch == 2'd2) begin
              ch    <= '0;
              state <= S_OUT;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_RMUL;
            end
          end
        end
        S_ADV: begin
          // all channels at the local goal: move on to the next stop
          if (at_goal) begin
            for (int c = 0; c < 3; c++) begin
              g[c] <= palette[next_local[STOP_W-1:0]][(2 - c) * CH_W +: CH_W];
            end
            local_stop <= next_local[STOP_W-1:0];
            ch         <= '0;
            state      <= S_WSET;
          end else begin
            state <= S_WALK;
          end
        end
        S_WSET: begin
          dvd    <= DVD_W'(walk_diff);
          div_go <= 1'b1;
          state  <= S_WDIV;
        end
        S_WDIV: begin
          if (div_done) begin
            d[ch] <= step_q;
            if (ch == 2'd2) begin
              ch    <= '0;
              state <= S_WALK;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_WSET;
            end
          end
        end
        S_WALK: begin
          // step toward the goal, snapping when closer than one step
          for (int c = 0; c < 3; c++) begin
            if (abs_diff(g[c], v[c]) < d[c]) begin
              v[c] <= g[c];
            end else if (g[c] > v[c]) begin
              v[c] <= v[c] + d[c];
            end else begin
              v[c] <= v[c] - d[c];
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (result_ready) begin
            if (pix == PIX_W'(NUM_PIXELS - 1)) begin
              // end of frame: advance ramp, goal stop and chase phase
              if (ramp_step == steps) begin
                ramp_step <= '0;
                goal_stop <= next_goal[STOP_W-1:0];
              end else begin
                ramp_step <= ramp_step + 1'b1;
              end
              if (first_lit && run_next > {1'b0, on_len}) begin
                first_run_count <= CH_W'(1);
                first_lit       <= 1'b0;
              end else if (!first_lit && run_next > {1'b0, off_len}) begin
                first_run_count <= CH_W'(1);
                first_lit       <= 1'b1;
              end else begin
                first_run_count <= run_next[CH_W-1:0];
              end
              pix   <= '0;
              state <= S_IDLE;
            end else begin
              pix   <= pix + 1'b1;
              state <= S_ADV;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
